// ----- rtl/dhfk_pkg.sv -----
// Shared types, constants and microcode for the DH forward kinematics chain.
// Used by dhfk_ctrl, dhfk_dpath and dh_forward_kinematics_chain.
`timescale 1ns / 1ps
package dhfk_pkg;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_EMIT} ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_X, OP_X2, OP_D42, OP_D20, OP_D6, OP_D56, OP_D30, OP_D12,
    OP_V, OP_SN, OP_CS, OP_FIX, OP_TM, OP_MAC, OP_COPY
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       ang;
    logic [3:0] idx;
    logic [1:0] k;
    logic       dep;
  } ucode_t;

  typedef struct packed {
    dp_op_t     op;
    logic       ang;
    logic [3:0] idx;
    logic [1:0] k;
    logic       load;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_stat_t;

  localparam int NumElem = 12;
  localparam logic [6:0] PcLast = 7'd76;
  localparam logic [3:0] ElemLast = 4'd11;

  localparam logic [30:0] Q30One = 31'h4000_0000;
  localparam logic signed [34:0] Q16One = 35'sd65536;
  localparam logic [33:0] PiQ32 = 34'd13493037705;

  // reciprocals: ceil(2^(31+l)/D), l = ceil(log2 D)
  localparam logic [63:0] M42 = ((64'd1 << 37) + 64'd41) / 64'd42;
  localparam logic [63:0] M20 = ((64'd1 << 36) + 64'd19) / 64'd20;
  localparam logic [63:0] M6  = ((64'd1 << 34) + 64'd5) / 64'd6;
  localparam logic [63:0] M56 = ((64'd1 << 37) + 64'd55) / 64'd56;
  localparam logic [63:0] M30 = ((64'd1 << 36) + 64'd29) / 64'd30;
  localparam logic [63:0] M12 = ((64'd1 << 35) + 64'd11) / 64'd12;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fff_ffff;
    if (v < -50'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] ident(input logic [3:0] i);
    return (i == 4'd0 || i == 4'd5 || i == 4'd10) ? 32'sd65536 : 32'sd0;
  endfunction

  // per item: two sin/cos, transform build, 3x4 product (k=3 adds pose column 3), copy
  function automatic ucode_t ucode(input logic [6:0] pc);
    ucode_t u;
    logic [6:0] s;
    logic [5:0] j;
    logic [5:0] w;
    logic [1:0] r;
    logic [1:0] c;
    u = '{op: OP_NOP, ang: 1'b0, idx: 4'd0, k: 2'd0, dep: 1'b0};
    s = 7'd0;
    j = 6'd0;
    w = 6'd0;
    r = 2'd0;
    c = 2'd0;
    if (pc < 7'd30) begin
      u.dep = 1'b1;
      u.ang = (pc >= 7'd15);
      s = (pc >= 7'd15) ? pc - 7'd15 : pc;
      unique case (s)
        7'd0:  u.op = OP_X;
        7'd1:  u.op = OP_X2;
        7'd2:  u.op = OP_D42;
        7'd3:  u.op = OP_V;
        7'd4:  u.op = OP_D20;
        7'd5:  u.op = OP_V;
        7'd6:  u.op = OP_D6;
        7'd7:  u.op = OP_SN;
        7'd8:  u.op = OP_D56;
        7'd9:  u.op = OP_V;
        7'd10: u.op = OP_D30;
        7'd11: u.op = OP_V;
        7'd12: u.op = OP_D12;
        7'd13: u.op = OP_V;
        default: u.op = OP_CS;
      endcase
    end else if (pc == 7'd30) begin
      u.op = OP_FIX;
    end else if (pc < 7'd37) begin
      u.op = OP_TM;
      unique case (pc)
        7'd31: u.idx = 4'd1;
        7'd32: u.idx = 4'd2;
        7'd33: u.idx = 4'd3;
        7'd34: u.idx = 4'd5;
        7'd35: u.idx = 4'd6;
        default: u.idx = 4'd7;
      endcase
    end else if (pc < PcLast) begin
      u.op = OP_MAC;
      j = 6'(pc - 7'd37);
      r = (j < 6'd13) ? 2'd0 : (j < 6'd26) ? 2'd1 : 2'd2;
      w = j - ((r == 2'd0) ? 6'd0 : (r == 2'd1) ? 6'd13 : 6'd26);
      c = (w < 6'd3) ? 2'd0 : (w < 6'd6) ? 2'd1 : (w < 6'd9) ? 2'd2 : 2'd3;
      u.k = 2'(w - 6'(3 * c));
      u.idx = {r, c};
    end else begin
      u.op = OP_COPY;
    end
    return u;
  endfunction

endpackage

// ----- rtl/dhfk_ctrl.sv -----
// Sequencer for the DH chain: input handshake, microcode issue, pose readout.
// Depends on dhfk_pkg.
`timescale 1ns / 1ps
module dhfk_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dhfk_pkg::dp_stat_t stat,
  output dhfk_pkg::dp_cmd_t  cmd
);
  import dhfk_pkg::*;

  ctrl_state_t state, state_next;
  logic [6:0]  pc, pc_next;
  logic        bubble, bubble_next;
  logic [3:0]  ecnt, ecnt_next;
  logic        out_valid_next;
  ucode_t      u;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= 7'd0;
      bubble    <= 1'b0;
      ecnt      <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      bubble    <= bubble_next;
      ecnt      <= ecnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    pc_next     = pc;
    bubble_next = bubble;
    ecnt_next   = ecnt;
    in_ready    = 1'b0;
    u           = ucode(pc);
    cmd         = '{op: OP_NOP, ang: 1'b0, idx: 4'd0, k: 2'd0, load: 1'b0, emit: 1'b0};
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load    = 1'b1;
          pc_next     = 7'd0;
          bubble_next = 1'b0;
          state_next  = ST_RUN;
        end
      end
      ST_RUN: begin
        if (bubble) begin
          bubble_next = 1'b0;
        end else begin
          cmd.op      = u.op;
          cmd.ang     = u.ang;
          cmd.idx     = u.idx;
          cmd.k       = u.k;
          bubble_next = u.dep;
          if (pc == PcLast) state_next = ST_DRAIN;
          else pc_next = pc + 7'd1;
        end
      end
      ST_DRAIN: begin
        ecnt_next  = 4'd0;
        state_next = stat.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit  = 1'b1;
          cmd.idx   = ecnt;
          ecnt_next = ecnt + 4'd1;
          if (ecnt == ElemLast) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    out_valid_next = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

endmodule

// ----- rtl/dhfk_dpath.sv -----
// Datapath for the DH chain: shared multiplier, sin/cos registers, transform,
// pose accumulator and output beat register. Depends on dhfk_pkg.
`timescale 1ns / 1ps
module dhfk_dpath (
  input  logic               clk,
  input  logic               rst,
  input  dhfk_pkg::dp_cmd_t  cmd,
  output dhfk_pkg::dp_stat_t stat,
  input  logic [95:0]        in_data,
  input  logic               in_last,
  output logic [3:0]         out_index,
  output logic [31:0]        out_value,
  output logic               out_last
);
  import dhfk_pkg::*;

  logic signed [31:0] d_in, a_in;
  logic [15:0]        theta, alpha;
  logic               last;

  logic [29:0] x, x2;
  logic [30:0] t, v, sn;
  logic signed [17:0] st, ct, sa, ca;
  logic signed [31:0] tm   [NumElem];
  logic signed [31:0] pose [NumElem];
  logic signed [31:0] nxt  [NumElem];
  logic signed [49:0] acc;

  logic signed [34:0] mul_a, mul_b;
  logic signed [69:0] prod;
  dp_op_t             op_d;
  logic               ang_d;
  logic [3:0]         idx_d;
  logic [1:0]         k_d;

  // angle reduction for the issuing op and for write-back
  logic [15:0] ang_i, ang_w;
  logic        swap_i, swap_w;
  logic [13:0] fr;

  logic [47:0]        xsum;
  logic [30:0]        q, cs;
  logic [30:0]        sn_r, cs_r;
  logic signed [17:0] s0, c0, s1, c1;
  logic signed [69:0] rnd;
  logic signed [49:0] sum;
  logic               fin;

  assign stat.last = last;

  assign ang_i  = cmd.ang ? alpha : theta;
  assign swap_i = ang_i[13:0] > 14'd8192;
  assign fr     = swap_i ? 14'(15'd16384 - {1'b0, ang_i[13:0]}) : ang_i[13:0];
  assign ang_w  = ang_d ? alpha : theta;
  assign swap_w = ang_w[13:0] > 14'd8192;

  always_comb begin
    mul_a = 35'sd0;
    mul_b = 35'sd0;
    unique case (cmd.op)
      OP_X:   begin mul_a = {21'd0, fr}; mul_b = {1'b0, PiQ32}; end
      OP_X2:  begin mul_a = {5'd0, x};   mul_b = {5'd0, x}; end
      OP_D42: begin mul_a = {5'd0, x2};  mul_b = {1'b0, M42[33:0]}; end
      OP_D56: begin mul_a = {5'd0, x2};  mul_b = {1'b0, M56[33:0]}; end
      OP_D20: begin mul_a = {4'd0, v};   mul_b = {1'b0, M20[33:0]}; end
      OP_D6:  begin mul_a = {4'd0, v};   mul_b = {1'b0, M6[33:0]}; end
      OP_D30: begin mul_a = {4'd0, v};   mul_b = {1'b0, M30[33:0]}; end
      OP_D12: begin mul_a = {4'd0, v};   mul_b = {1'b0, M12[33:0]}; end
      OP_V:   begin mul_a = {5'd0, x2};  mul_b = {4'd0, t}; end
      OP_SN:  begin mul_a = {5'd0, x};   mul_b = {4'd0, t}; end
      OP_TM: begin
        unique case (cmd.idx)
          4'd1:    begin mul_a = -35'(st); mul_b = 35'(ca); end
          4'd2:    begin mul_a = 35'(st);  mul_b = 35'(sa); end
          4'd3:    begin mul_a = 35'(a_in); mul_b = 35'(ct); end
          4'd5:    begin mul_a = 35'(ct);  mul_b = 35'(ca); end
          4'd6:    begin mul_a = -35'(ct); mul_b = 35'(sa); end
          default: begin mul_a = 35'(a_in); mul_b = 35'(st); end
        endcase
      end
      OP_MAC: begin
        mul_a = 35'(pose[{cmd.idx[3:2], cmd.k}]);
        mul_b = (cmd.k == 2'd3) ? Q16One : 35'(tm[{cmd.k, cmd.idx[1:0]}]);
      end
      default: ;
    endcase
  end

  // write-back arithmetic
  always_comb begin
    xsum = prod[47:0] + 48'd65536;
    unique case (op_d)
      OP_D42, OP_D56: q = prod[67:37];
      OP_D20, OP_D30: q = prod[66:36];
      OP_D12:         q = prod[65:35];
      default:        q = prod[64:34];
    endcase
    cs   = Q30One - {1'b0, v[30:1]};
    sn_r = sn + 31'd8192;
    cs_r = cs + 31'd8192;
    s0   = swap_w ? {1'b0, cs_r[30:14]} : {1'b0, sn_r[30:14]};
    c0   = swap_w ? {1'b0, sn_r[30:14]} : {1'b0, cs_r[30:14]};
    case (ang_w[15:14])
      2'd0:    begin s1 = s0;  c1 = c0; end
      2'd1:    begin s1 = c0;  c1 = -s0; end
      2'd2:    begin s1 = -s0; c1 = -c0; end
      default: begin s1 = -c0; c1 = s0; end
    endcase
    rnd = (prod + 70'sd32768) >>> 16;
    sum = ((k_d == 2'd0) ? 50'sd0 : acc) + rnd[49:0];
    fin = (idx_d[1:0] == 2'd3) ? (k_d == 2'd3) : (k_d == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_d <= OP_NOP;
      for (int i = 0; i < NumElem; i++) pose[i] <= ident(4'(i));
    end else begin
      op_d <= cmd.op;
      if (op_d == OP_COPY) begin
        for (int i = 0; i < NumElem; i++) pose[i] <= last ? ident(4'(i)) : nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    prod  <= mul_a * mul_b;
    ang_d <= cmd.ang;
    idx_d <= cmd.idx;
    k_d   <= cmd.k;
    if (cmd.load) begin
      d_in  <= in_data[31:0];
      theta <= in_data[47:32];
      a_in  <= in_data[79:48];
      alpha <= in_data[95:80];
      last  <= in_last;
    end
    if (cmd.emit) begin
      out_index <= cmd.idx;
      out_value <= nxt[cmd.idx];
      out_last  <= (cmd.idx == ElemLast);
    end
    unique case (op_d)
      OP_X:  x  <= xsum[46:17];
      OP_X2: x2 <= prod[59:30];
      OP_D42, OP_D20, OP_D6, OP_D56, OP_D30, OP_D12: t <= Q30One - q;
      OP_V:  v  <= prod[60:30];
      OP_SN: sn <= prod[60:30];
      OP_CS: begin
        if (ang_d) begin
          sa <= s1;
          ca <= c1;
        end else begin
          st <= s1;
          ct <= c1;
        end
      end
      OP_FIX: begin
        tm[0]  <= 32'(ct);
        tm[4]  <= 32'(st);
        tm[8]  <= 32'sd0;
        tm[9]  <= 32'(sa);
        tm[10] <= 32'(ca);
        tm[11] <= d_in;
      end
      OP_TM: tm[idx_d] <= sat32(rnd[49:0]);
      OP_MAC: begin
        acc <= sum;
        if (fin) nxt[idx_d] <= sat32(sum);
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/dh_forward_kinematics_chain.sv -----
// Denavit-Hartenberg forward kinematics chain, top level.
// Each joint beat is accepted, then runs 30 dependent sin/cos multiplier steps, each followed by
// a bubble, then 46 pipelined transform/product steps, copy and drain, all on the single shared
// 35x35 multiplier; the next joint beat is accepted only once the block is back in idle. The
// last joint adds 12 output beats plus any output stalls.
// One joint in flight at a time. Synchronous reset loads the identity pose.
`timescale 1ns / 1ps
module dh_forward_kinematics_chain (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // joint_offset, joint_angle, link_length, link_twist
  input  logic        s_axis_tlast,   // last_joint
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // element_value
  output logic [3:0]  m_axis_tuser,   // element_index
  output logic        m_axis_tlast    // last_element
);
  import dhfk_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dhfk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dhfk_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .out_index (m_axis_tuser),
    .out_value (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
